@@ design/mdcs_pkg.sv @@
package mdcs_pkg;

  // Measured current width and lamp level width
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned LVL_W    = 10;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned CNT_W    = 8;
  // Compare width: widest operand plus one bit so a difference never wraps
  localparam int unsigned CMP_W    = ((SAMPLE_W > LVL_W) ? SAMPLE_W : LVL_W) + 1;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // Second counter skips this value and restarts at zero
  localparam logic [CNT_W-1:0] SEC_WRAP = CNT_W'(255);

  localparam logic [LVL_W-1:0]  RST_BRIGHT    = LVL_W'(1023);
  localparam logic [LVL_W-1:0]  RST_DIM       = LVL_W'(300);
  localparam logic [STEP_W-1:0] RST_STEP_UP   = STEP_W'(4);
  localparam logic [STEP_W-1:0] RST_STEP_DOWN = STEP_W'(4);
  localparam logic [CNT_W-1:0]  RST_HOLD_S    = CNT_W'(10);
  localparam logic [STEP_W-1:0] RST_MIN_STEP  = STEP_W'(1);
  localparam logic [CNT_W-1:0]  RST_TPS       = CNT_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHT    = 3'd0,
    REG_DIM       = 3'd1,
    REG_STEP_UP   = 3'd2,
    REG_STEP_DOWN = 3'd3,
    REG_HOLD_S    = 3'd4,
    REG_MIN_STEP  = 3'd5,
    REG_TPS       = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef struct packed {
    logic [LVL_W-1:0]  bright_level;
    logic [LVL_W-1:0]  dim_level;
    logic [STEP_W-1:0] step_up;
    logic [STEP_W-1:0] step_down;
    logic [CNT_W-1:0]  hold_seconds;
    logic [STEP_W-1:0] min_step;
    logic [CNT_W-1:0]  ticks_per_second;
  } cfg_t;

  typedef struct packed {
    op_t                 op;
    logic [SAMPLE_W-1:0] current_sample;
    logic                sensor_idle;
  } item_t;

  typedef struct packed {
    logic              sample_request;
    logic [LVL_W-1:0]  target_level;
    logic [STEP_W-1:0] step_size;
    logic              above_target;
    logic              adjust;
  } res_t;

endpackage

@@ design/motion_dimmer_current_stepper_top.sv @@
// A request is registered in the input register on acceptance, and its result moves
//   to the output register once that is free. Throughput: one request per cycle
//   while out_tready keeps up; set by the single update pass in mdcs_core.
// Reset: synchronous, active-low rst_n clears valids and counters, target 1023,
//   and loads the register defaults (bright 1023, dim 300, steps 4/4, hold 10 s,
//   min step 1, 100 ticks per second).
module motion_dimmer_current_stepper_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,  // [9:0] current_sample, [10] sensor_idle
  input  logic [0:0]                      in_tuser,  // [0] op (0 tick, 1 sample)
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] adjust, [1] above_target, [9:2] step_size, [19:10] target_level,
  // [20] sample_request
  output logic [23:0]                     out_tdata,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [mdcs_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [mdcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned RES_W = $bits(mdcs_pkg::res_t);

  mdcs_pkg::cfg_t  cfg;
  mdcs_pkg::item_t item_r;
  mdcs_pkg::res_t  res;
  mdcs_pkg::res_t  res_r;
  logic            item_vld_r;
  logic            out_vld_r;
  logic            out_free;
  logic            advance;

  // Output register frees up when empty or being drained this cycle.
  assign out_free  = !out_vld_r || out_tready;
  // Input stage hands its request to the output register whenever there is room;
  // the state registers update on that same edge.
  assign advance   = item_vld_r && out_free;
  assign in_tready = !item_vld_r || out_free;

  mdcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mdcs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cfg     (cfg),
    .item    (item_r),
    .res     (res)
  );

  // Input register: payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.op             <= mdcs_pkg::op_t'(in_tuser[0]);
      item_r.current_sample <= in_tdata[mdcs_pkg::SAMPLE_W-1:0];
      item_r.sensor_idle    <= in_tdata[mdcs_pkg::SAMPLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= item_vld_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(24 - RES_W)'(0), res_r};

endmodule

@@ design/mdcs_cfg_regs.sv @@
module mdcs_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mdcs_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [mdcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mdcs_pkg::cfg_t                  cfg
);

  mdcs_pkg::cfg_t cfg_r;
  mdcs_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        mdcs_pkg::REG_BRIGHT:    cfg_nxt.bright_level     = cfg_wdata[mdcs_pkg::LVL_W-1:0];
        mdcs_pkg::REG_DIM:       cfg_nxt.dim_level        = cfg_wdata[mdcs_pkg::LVL_W-1:0];
        mdcs_pkg::REG_STEP_UP:   cfg_nxt.step_up          = cfg_wdata[mdcs_pkg::STEP_W-1:0];
        mdcs_pkg::REG_STEP_DOWN: cfg_nxt.step_down        = cfg_wdata[mdcs_pkg::STEP_W-1:0];
        mdcs_pkg::REG_HOLD_S:    cfg_nxt.hold_seconds     = cfg_wdata[mdcs_pkg::CNT_W-1:0];
        mdcs_pkg::REG_MIN_STEP:  cfg_nxt.min_step         = cfg_wdata[mdcs_pkg::STEP_W-1:0];
        mdcs_pkg::REG_TPS:       cfg_nxt.ticks_per_second = cfg_wdata[mdcs_pkg::CNT_W-1:0];
        default:                 cfg_nxt = cfg_r;  // unused index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bright_level     <= mdcs_pkg::RST_BRIGHT;
      cfg_r.dim_level        <= mdcs_pkg::RST_DIM;
      cfg_r.step_up          <= mdcs_pkg::RST_STEP_UP;
      cfg_r.step_down        <= mdcs_pkg::RST_STEP_DOWN;
      cfg_r.hold_seconds     <= mdcs_pkg::RST_HOLD_S;
      cfg_r.min_step         <= mdcs_pkg::RST_MIN_STEP;
      cfg_r.ticks_per_second <= mdcs_pkg::RST_TPS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/mdcs_core.sv @@
module mdcs_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  mdcs_pkg::cfg_t cfg,
  input  mdcs_pkg::item_t item,
  output mdcs_pkg::res_t res
);

  logic [mdcs_pkg::CNT_W-1:0] tick_count_r, tick_count_nxt;
  logic [mdcs_pkg::CNT_W-1:0] second_count_r, second_count_nxt;
  logic                       hold_running_r, hold_running_nxt;
  logic                       hold_done_r, hold_done_nxt;
  logic                       step_pending_r, step_pending_nxt;
  logic [mdcs_pkg::LVL_W-1:0] target_now_r, target_now_nxt;

  logic [mdcs_pkg::CNT_W-1:0]  tick_inc;
  logic [mdcs_pkg::CNT_W-1:0]  sec_inc;
  logic [mdcs_pkg::CMP_W-1:0]  smp_x;
  logic [mdcs_pkg::CMP_W-1:0]  tgt_x;
  logic [mdcs_pkg::CMP_W-1:0]  gap_dn;
  logic [mdcs_pkg::CMP_W-1:0]  gap_up;
  logic [mdcs_pkg::CMP_W-1:0]  down_x;
  logic [mdcs_pkg::CMP_W-1:0]  up_x;

  assign tick_inc = tick_count_r + mdcs_pkg::CNT_W'(1);
  assign sec_inc  = second_count_r + mdcs_pkg::CNT_W'(1);
  assign smp_x    = mdcs_pkg::CMP_W'(item.current_sample);
  assign down_x   = mdcs_pkg::CMP_W'(cfg.step_down);
  assign up_x     = mdcs_pkg::CMP_W'(cfg.step_up);

  always_comb begin
    tick_count_nxt   = tick_count_r;
    second_count_nxt = second_count_r;
    hold_running_nxt = hold_running_r;
    hold_done_nxt    = hold_done_r;
    step_pending_nxt = step_pending_r;
    target_now_nxt   = target_now_r;
    tgt_x            = mdcs_pkg::CMP_W'(target_now_r);
    gap_dn           = '0;
    gap_up           = '0;
    res              = '0;

    if (item.op == mdcs_pkg::OP_TICK) begin
      if (step_pending_r) begin
        step_pending_nxt   = 1'b0;
        res.sample_request = 1'b1;
      end
      // zero ticks_per_second falls through here as well: every tick is a second
      if (tick_inc >= cfg.ticks_per_second) begin
        tick_count_nxt     = '0;
        second_count_nxt   = (sec_inc == mdcs_pkg::SEC_WRAP) ? '0 : sec_inc;
        res.sample_request = 1'b1;
      end else begin
        tick_count_nxt = tick_inc;
      end
    end else begin
      priority if (!item.sensor_idle) begin
        target_now_nxt   = cfg.bright_level;
        second_count_nxt = '0;
        hold_running_nxt = 1'b0;
        hold_done_nxt    = 1'b0;
      end else if (!hold_running_r) begin
        second_count_nxt = '0;
        hold_running_nxt = 1'b1;
        hold_done_nxt    = 1'b0;
      end else if (hold_done_r) begin
        target_now_nxt = cfg.dim_level;
      end else if (second_count_r >= cfg.hold_seconds) begin
        hold_done_nxt  = 1'b1;
        target_now_nxt = cfg.dim_level;
      end else begin
        target_now_nxt = target_now_r;
      end

      // compare against the target as updated by this sample
      tgt_x  = mdcs_pkg::CMP_W'(target_now_nxt);
      gap_dn = smp_x - tgt_x;
      gap_up = tgt_x - smp_x;

      priority if (smp_x > tgt_x) begin
        res.step_size    = (gap_dn <= down_x) ? cfg.min_step : cfg.step_down;
        res.above_target = 1'b1;
        res.adjust       = 1'b1;
        step_pending_nxt = 1'b1;
      end else if (smp_x < tgt_x) begin
        res.step_size    = (gap_up <= up_x) ? cfg.min_step : cfg.step_up;
        res.adjust       = 1'b1;
        step_pending_nxt = 1'b1;
      end else begin
        res.adjust = 1'b0;
      end
    end
    res.target_level = target_now_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r   <= '0;
      second_count_r <= '0;
      hold_running_r <= 1'b0;
      hold_done_r    <= 1'b0;
      step_pending_r <= 1'b0;
      target_now_r   <= mdcs_pkg::RST_BRIGHT;
    end else if (advance) begin
      tick_count_r   <= tick_count_nxt;
      second_count_r <= second_count_nxt;
      hold_running_r <= hold_running_nxt;
      hold_done_r    <= hold_done_nxt;
      step_pending_r <= step_pending_nxt;
      target_now_r   <= target_now_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    hold_done_r |-> hold_running_r)
    else $error("hold done without hold timer running");

  a_sec_skips_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    second_count_r != mdcs_pkg::SEC_WRAP)
    else $error("second counter reached wrap value");

  a_step_marks_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.adjust) |=> step_pending_r)
    else $error("issued step did not set pending flag");

  a_tick_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    (item.op == mdcs_pkg::OP_TICK) |-> !res.adjust && res.step_size == '0)
    else $error("tick produced a drive step");
`endif

endmodule

@@ tb/sv/mdcs_step_checker.sv @@
`timescale 1ns / 1ps
module mdcs_step_checker
  import mdcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [15:0]           in_tdata,  // [9:0] current_sample, [10] sensor_idle
  input  logic [0:0]            in_tuser,  // [0] op
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] adjust, [1] above_target, [9:2] step_size, [19:10] target_level,
  // [20] sample_request
  input  logic [23:0]           out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  cfg_t              lamp_cfg;
  logic [CNT_W-1:0]  tick_cnt;
  logic [CNT_W-1:0]  sec_cnt;
  logic              hold_on;
  logic              hold_expired;
  logic              step_owed;
  logic [LVL_W-1:0]  target_lvl;
  res_t              expected_steps[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic res_t predict_step(item_t it);
    res_t r;
    int   gap;
    r = '0;
    if (it.op == OP_TICK) begin
      if (step_owed) begin
        step_owed        = 1'b0;
        r.sample_request = 1'b1;
      end
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= lamp_cfg.ticks_per_second) begin
        tick_cnt = '0;
        sec_cnt  = sec_cnt + 1'b1;
        if (sec_cnt == SEC_WRAP) sec_cnt = '0;
        r.sample_request = 1'b1;
      end
    end else begin
      if (!it.sensor_idle) begin
        target_lvl   = lamp_cfg.bright_level;
        sec_cnt      = '0;
        hold_on      = 1'b0;
        hold_expired = 1'b0;
      end else if (!hold_on) begin
        sec_cnt      = '0;
        hold_on      = 1'b1;
        hold_expired = 1'b0;
      end else if (hold_expired) begin
        target_lvl = lamp_cfg.dim_level;
      end else if (sec_cnt >= lamp_cfg.hold_seconds) begin
        hold_expired = 1'b1;
        target_lvl   = lamp_cfg.dim_level;
      end
      gap = int'(it.current_sample) - int'(target_lvl);
      if (gap > 0) begin
        r.step_size    = (gap <= int'(lamp_cfg.step_down)) ? lamp_cfg.min_step
                                                           : lamp_cfg.step_down;
        r.above_target = 1'b1;
        r.adjust       = 1'b1;
        step_owed      = 1'b1;
      end else if (gap < 0) begin
        r.step_size = (-gap <= int'(lamp_cfg.step_up)) ? lamp_cfg.min_step
                                                       : lamp_cfg.step_up;
        r.adjust    = 1'b1;
        step_owed   = 1'b1;
      end
    end
    r.target_level = target_lvl;
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    item_t it;
    res_t  want;
    res_t  got;
    if (!rst_n) begin
      lamp_cfg     = '{bright_level: RST_BRIGHT, dim_level: RST_DIM,
                       step_up: RST_STEP_UP, step_down: RST_STEP_DOWN,
                       hold_seconds: RST_HOLD_S, min_step: RST_MIN_STEP,
                       ticks_per_second: RST_TPS};
      tick_cnt     = '0;
      sec_cnt      = '0;
      hold_on      = 1'b0;
      hold_expired = 1'b0;
      step_owed    = 1'b0;
      target_lvl   = RST_BRIGHT;
      expected_steps.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          REG_BRIGHT:    lamp_cfg.bright_level     = cfg_wdata[LVL_W-1:0];
          REG_DIM:       lamp_cfg.dim_level        = cfg_wdata[LVL_W-1:0];
          REG_STEP_UP:   lamp_cfg.step_up          = cfg_wdata[STEP_W-1:0];
          REG_STEP_DOWN: lamp_cfg.step_down        = cfg_wdata[STEP_W-1:0];
          REG_HOLD_S:    lamp_cfg.hold_seconds     = cfg_wdata[CNT_W-1:0];
          REG_MIN_STEP:  lamp_cfg.min_step         = cfg_wdata[STEP_W-1:0];
          REG_TPS:       lamp_cfg.ticks_per_second = cfg_wdata[CNT_W-1:0];
          default: ;  // unmapped index, no effect
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[$bits(res_t)-1:0]);
        if (expected_steps.size() == 0) begin
          $error("result with nothing expected: out_tdata 0x%06h", out_tdata);
          fail_count++;
        end else begin
          want = expected_steps.pop_front();
          check_field("adjust", want.adjust, got.adjust);
          check_field("above_target", want.above_target, got.above_target);
          check_field("step_size", want.step_size, got.step_size);
          check_field("target_level", want.target_level, got.target_level);
          check_field("sample_request", want.sample_request, got.sample_request);
        end
      end
      if (in_tvalid && in_tready) begin
        it.op             = op_t'(in_tuser[0]);
        it.current_sample = in_tdata[SAMPLE_W-1:0];
        it.sensor_idle    = in_tdata[SAMPLE_W];
        expected_steps.push_back(predict_step(it));
      end
    end
    pending = expected_steps.size();
  end

endmodule

@@ tb/sv/motion_dimmer_current_stepper_top_tb.sv @@
`timescale 1ns / 1ps
module motion_dimmer_current_stepper_top_tb;
  import mdcs_pkg::*;

  // Index past the register map; writes there must not change anything
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG = '1;
  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 190;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata   = '0;  // [9:0] current_sample, [10] sensor_idle
  logic [0:0]            in_tuser   = '0;  // [0] op (0 tick, 1 sample)
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [0] adjust, [1] above_target, [9:2] step_size, [19:10] target_level,
  // [20] sample_request
  logic [23:0]           out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int fail_count;
  int pending;

  // Stimulus knobs: percent of cycles the sender idles / receiver stalls
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   reqs_sent      = 0;
  cfg_t cur_cfg;  // mirror of what was programmed, used to aim samples

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  motion_dimmer_current_stepper_top DUT (.*);

  mdcs_step_checker u_checker (.*);

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Hard stop in case a handshake never completes
  initial begin
    #(20_000_000);
    $display("TB_ERROR");
    $finish;
  end

  // One request; returns at the edge where it was accepted with tvalid left high,
  // so back-to-back requests never drop tvalid in between.
  task automatic send_req(op_t op, logic [SAMPLE_W-1:0] sample, logic idle);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= 16'({idle, sample});
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    reqs_sent++;
  endtask

  // Hold off until every expected result is in, then let the pipe settle.
  // Counts are read at the falling edge so they are stable.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Program the whole map; the 8-bit registers get junk in the upper data bits
  // to make sure they are dropped.
  task automatic write_regs(cfg_t c);
    write_reg(REG_BRIGHT, c.bright_level);
    write_reg(REG_DIM, c.dim_level);
    write_reg(REG_STEP_UP, {2'($urandom), c.step_up});
    write_reg(UNMAPPED_REG, CFG_DATA_W'($urandom));
    write_reg(REG_STEP_DOWN, {2'($urandom), c.step_down});
    write_reg(REG_HOLD_S, {2'($urandom), c.hold_seconds});
    write_reg(REG_MIN_STEP, {2'($urandom), c.min_step});
    write_reg(REG_TPS, {2'($urandom), c.ticks_per_second});
    cfg_we  <= 1'b0;
    cur_cfg  = c;
  endtask

  // Short seconds and short hold times so dimming actually happens
  function automatic cfg_t random_cfg();
    cfg_t c;
    c.bright_level     = LVL_W'($urandom);
    c.dim_level        = LVL_W'($urandom);
    c.step_up          = ($urandom_range(9) == 0) ? 8'hff : 8'($urandom_range(40));
    c.step_down        = ($urandom_range(9) == 0) ? 8'hff : 8'($urandom_range(40));
    c.hold_seconds     = 8'($urandom_range(6));
    c.min_step         = 8'($urandom);
    c.ticks_per_second = 8'($urandom_range(4));
    return c;
  endfunction

  // Half the samples land near a target level so the min-step window and the
  // equal case get hit; the rest are anywhere or at the rails.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int span;
    int v;
    int top_v;
    top_v = (1 << SAMPLE_W) - 1;
    span  = (cur_cfg.step_up > cur_cfg.step_down) ? cur_cfg.step_up : cur_cfg.step_down;
    case ($urandom_range(3))
      0:       v = int'(cur_cfg.bright_level);
      1:       v = int'(cur_cfg.dim_level);
      2:       return SAMPLE_W'($urandom);
      default: return $urandom_range(1) ? '1 : '0;
    endcase
    v = v - span - 2 + int'($urandom_range(2 * span + 4));
    if (v < 0) v = 0;
    if (v > top_v) v = top_v;
    return SAMPLE_W'(v);
  endfunction

  // Ticks carry random payload, which the block must ignore
  task automatic send_tick();
    send_req(OP_TICK, SAMPLE_W'($urandom), 1'($urandom));
  endtask

  task automatic random_req();
    int k;
    k = $urandom_range(99);
    if (k < 1 && cur_cfg.ticks_per_second <= 1) begin
      // long tick run: second counter goes past its wrap point
      repeat (260) send_tick();
    end else if (k < 10) begin
      repeat ($urandom_range(3, 30)) send_tick();
    end else if (k < 55) begin
      send_tick();
    end else begin
      send_req(OP_SAMPLE, pick_sample(), $urandom_range(99) < 70);
    end
  endtask

  initial begin
    cfg_t mode_cfg;
    int   phase_end;
    cur_cfg = '{bright_level: RST_BRIGHT, dim_level: RST_DIM, step_up: RST_STEP_UP,
                step_down: RST_STEP_DOWN, hold_seconds: RST_HOLD_S,
                min_step: RST_MIN_STEP, ticks_per_second: RST_TPS};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed, reset defaults ----
    send_req(OP_TICK, '0, 1'b0);          // nothing pending, no second yet
    send_req(OP_SAMPLE, 10'd1023, 1'b0);  // motion, sample equals target
    send_req(OP_SAMPLE, 10'd0, 1'b0);     // far below: full step up
    send_req(OP_TICK, '1, 1'b1);          // pending step raises sample_request
    send_req(OP_SAMPLE, 10'd1020, 1'b0);  // gap inside step: min step
    send_req(OP_SAMPLE, 10'd1023, 1'b1);  // no motion: hold timer starts
    send_req(OP_SAMPLE, 10'd1023, 1'b1);  // hold not yet expired
    drain();

    // ---- directed, extremes: zero hold, zero ticks per second ----
    write_regs('{bright_level: 10'd0, dim_level: 10'd1023, step_up: 8'hff,
                 step_down: 8'hff, hold_seconds: 8'd0, min_step: 8'd0,
                 ticks_per_second: 8'd0});
    send_req(OP_SAMPLE, 10'd1023, 1'b0);  // target 0, far above: step down
    send_req(OP_SAMPLE, 10'd200, 1'b1);   // timer starts, gap inside step
    send_req(OP_SAMPLE, 10'd0, 1'b1);     // zero hold: dim on second idle sample
    send_req(OP_TICK, '0, 1'b0);          // every tick is a full second
    send_req(OP_SAMPLE, 10'd1023, 1'b1);  // hold already done, equal
    send_req(OP_TICK, '1, 1'b1);
    drain();

    // ---- directed, other extremes: zero steps, max hold and seconds ----
    write_regs('{bright_level: 10'd1023, dim_level: 10'd0, step_up: 8'd0,
                 step_down: 8'd0, hold_seconds: 8'hff, min_step: 8'hff,
                 ticks_per_second: 8'hff});
    send_req(OP_SAMPLE, 10'd1023, 1'b0);
    send_req(OP_SAMPLE, 10'd1022, 1'b0);  // below by one with zero step
    send_req(OP_SAMPLE, 10'd0, 1'b1);
    send_req(OP_SAMPLE, 10'd512, 1'b1);
    send_req(OP_TICK, '0, 1'b0);
    send_req(OP_TICK, '0, 1'b0);

    // ---- random phases: new settings and a new idle pattern each ----
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();  // sender waits for every result before reprogramming
      case (ph)
        1:       mode_cfg = '{bright_level: '1, dim_level: '0, step_up: '1,
                              step_down: '1, hold_seconds: '1, min_step: '1,
                              ticks_per_second: '1};
        2:       mode_cfg = '0;
        3: begin
          mode_cfg = random_cfg();
          mode_cfg.ticks_per_second = 8'd1;
        end
        default: mode_cfg = random_cfg();
      endcase
      write_regs(mode_cfg);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      phase_end = reqs_sent + PHASE_REQS;
      while (reqs_sent < phase_end) random_req();
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
